/* rtl/lec_pkg.sv */
// shared types and codes for the rgb lamp effect controller
// no dependencies; used by lec_update and rgb_lamp_effect_controller_core
package lec_pkg;

	localparam int ItemWidth = 40;
	localparam int OpWidth   = 3;
	localparam logic [7:0] LevelMax  = 8'd255;
	localparam logic [7:0] PulseStep = 8'd3;

	typedef enum logic [2:0] {
		OP_TICK       = 3'd0,
		OP_TOGGLE     = 3'd1,
		OP_SET_COLOR  = 3'd2,
		OP_SET_BRIGHT = 3'd3,
		OP_SET_EFFECT = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		FX_NONE    = 2'd0,
		FX_RAINBOW = 2'd1,
		FX_PULSE   = 2'd2
	} fx_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} color_t;

	localparam color_t ColorBlack = '{blue: 8'h00, green: 8'h00, red: 8'h00};
	localparam color_t ColorWhite = '{blue: 8'hFF, green: 8'hFF, red: 8'hFF};

	// one input item, fields in tdata order
	typedef struct packed {
		logic [2:0] op;
		logic [1:0] effect;
		logic [7:0] brightness;
		color_t     color;
		logic       switch_on;
	} item_t;

	// lamp state carried from item to item
	typedef struct packed {
		color_t     shown;
		color_t     saved;
		logic [7:0] brightness;
		logic [1:0] effect;
		color_t     wheel;
		logic [7:0] pulse_level;
		logic       pulse_rising;
	} lamp_state_t;

	localparam lamp_state_t StateReset = '{
		shown:        ColorBlack,
		saved:        ColorWhite,
		brightness:   LevelMax,
		effect:       FX_NONE,
		wheel:        ColorBlack,
		pulse_level:  8'd0,
		pulse_rising: 1'b1
	};

endpackage

/* rtl/lec_update.sv */
// next-state logic for one lamp event: toggle, color, brightness, effect, tick
// depends on lec_pkg
module lec_update (
	input  lec_pkg::item_t       item,
	input  lec_pkg::lamp_state_t cur,
	output lec_pkg::lamp_state_t nxt
);
	import lec_pkg::*;

	color_t     wheel_step;
	logic       rising;
	logic [8:0] level_up;
	logic [7:0] level_next;

	// one unit along the six sides of the color wheel
	always_comb begin
		wheel_step = cur.wheel;
		if (cur.wheel.red == 8'hFF && cur.wheel.green != 8'hFF && cur.wheel.blue == 8'h00) begin
			wheel_step.green = cur.wheel.green + 8'd1;
		end else if (cur.wheel.red != 8'h00 && cur.wheel.green == 8'hFF
				&& cur.wheel.blue == 8'h00) begin
			wheel_step.red = cur.wheel.red - 8'd1;
		end else if (cur.wheel.red == 8'h00 && cur.wheel.green == 8'hFF
				&& cur.wheel.blue != 8'hFF) begin
			wheel_step.blue = cur.wheel.blue + 8'd1;
		end else if (cur.wheel.red == 8'h00 && cur.wheel.green != 8'h00
				&& cur.wheel.blue == 8'hFF) begin
			wheel_step.green = cur.wheel.green - 8'd1;
		end else if (cur.wheel.red != 8'hFF && cur.wheel.green == 8'h00
				&& cur.wheel.blue == 8'hFF) begin
			wheel_step.red = cur.wheel.red + 8'd1;
		end else if (cur.wheel.red == 8'hFF && cur.wheel.green == 8'h00
				&& cur.wheel.blue != 8'h00) begin
			wheel_step.blue = cur.wheel.blue - 8'd1;
		end
	end

	// pulse turns at the ends, then moves with saturation
	always_comb begin
		if (cur.pulse_level == 8'd0) begin
			rising = 1'b1;
		end else if (cur.pulse_level == LevelMax) begin
			rising = 1'b0;
		end else begin
			rising = cur.pulse_rising;
		end
		level_up = {1'b0, cur.pulse_level} + {1'b0, PulseStep};
		if (rising) begin
			level_next = level_up[8] ? LevelMax : level_up[7:0];
		end else begin
			level_next = (cur.pulse_level < PulseStep) ? 8'd0 : cur.pulse_level - PulseStep;
		end
	end

	always_comb begin
		nxt = cur;
		case (item.op)
			OP_TICK: begin
				if (cur.effect == FX_RAINBOW) begin
					nxt.shown = cur.wheel;
					nxt.wheel = wheel_step;
				end else if (cur.effect == FX_PULSE) begin
					nxt.pulse_rising = rising;
					nxt.pulse_level  = level_next;
					nxt.brightness   = level_next;
				end
			end
			OP_TOGGLE: begin
				if (item.switch_on) begin
					nxt.shown = cur.saved;
				end else begin
					nxt.saved = cur.shown;
					nxt.shown = ColorBlack;
				end
			end
			OP_SET_COLOR: begin
				nxt.saved = item.color;
				nxt.shown = item.color;
			end
			OP_SET_BRIGHT: begin
				nxt.brightness = item.brightness;
			end
			OP_SET_EFFECT: begin
				if (item.effect == FX_RAINBOW) begin
					nxt.effect = FX_RAINBOW;
					nxt.wheel  = cur.shown;
				end else if (item.effect == FX_PULSE) begin
					nxt.effect       = FX_PULSE;
					nxt.pulse_level  = cur.brightness;
					nxt.pulse_rising = 1'b0;
				end else begin
					nxt.effect = FX_NONE;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

/* rtl/rgb_lamp_effect_controller_core.sv */
// top level of the rgb lamp effect controller: input stage, lamp state, result register
// depends on lec_pkg and lec_update
//
// usage
//   the slave side takes one lamp event per transfer: the operation code rides in
//   s_tuser, its arguments in s_tdata. the master side returns exactly one result
//   per event: on flag, shown color, brightness and active effect after the event.
// pipeline and throughput
//   an event is registered at the input stage and applied to the lamp state as it
//   leaves that stage; its result lands in the output register at the same edge,
//   which drives m_tvalid. one event per cycle is taken while m_tready is high or
//   no result waits; the state update is a single short pass of compares and 8-bit
//   adds.
// reset
//   arst_n clears both stages; the lamp shows black with white saved, brightness
//   255, no effect, wheel color black, pulse level 0 rising.
// stall
//   when m_tready is low with a result waiting, the input stage holds its event and
//   s_tready drops only once that stage is occupied, so nothing is lost or repeated.
module rgb_lamp_effect_controller_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// switch_on[0], red[8:1], green[16:9], blue[24:17], brightness[32:25],
	// effect[34:33], zero fill[39:35]
	input  logic [lec_pkg::ItemWidth-1:0]     s_tdata,
	// operation[2:0]
	input  logic [lec_pkg::OpWidth-1:0]       s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// lamp_on[0], red[8:1], green[16:9], blue[24:17], brightness[32:25],
	// effect[34:33], zero fill[39:35]
	output logic [lec_pkg::ItemWidth-1:0]     m_tdata
);
	import lec_pkg::*;

	item_t       item_s1;
	logic        valid_s1;
	logic        advance;
	lamp_state_t state_q;
	lamp_state_t state_next;
	logic [ItemWidth-1:0] result_q;
	logic                 result_valid_q;

	// the pipe moves whenever the result register is empty or being drained
	assign advance  = !result_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	// input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.switch_on  <= s_tdata[0];
			item_s1.color      <= '{blue: s_tdata[24:17], green: s_tdata[16:9],
				red: s_tdata[8:1]};
			item_s1.brightness <= s_tdata[32:25];
			item_s1.effect     <= s_tdata[34:33];
			item_s1.op         <= s_tuser;
		end
	end

	lec_update u_update (
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_next)
	);

	// lamp state, updated once per event as it leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StateReset;
		end else if (advance && valid_s1) begin
			state_q <= state_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q <= {5'd0, state_next.effect, state_next.brightness,
				state_next.shown.blue, state_next.shown.green, state_next.shown.red,
				|state_next.shown};
		end
	end

	assign m_tvalid = result_valid_q;
	assign m_tdata  = result_q;

	// on flag always agrees with the color it reports
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (|m_tdata[24:1])))
		else $error("lamp_on disagrees with shown color");

	// stored effect never holds the unused code
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.effect <= FX_PULSE)
		else $error("effect state holds unused code");

	// an empty input stage always takes a transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled while empty");

endmodule

/* tb/sv/rgb_lamp_effect_controller_core_test.sv */
// self-checking testbench for rgb_lamp_effect_controller_core: lamp events in, one lamp view out
// depends on lec_pkg and the core rtl; a local lamp model predicts every result
module rgb_lamp_effect_controller_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lec_pkg::*;

	localparam int CycleLimit     = 200000;
	localparam int DrainCycles    = 10;
	localparam int RandomPerPhase = 475;
	localparam int LongHold       = 400;

	// operation codes the core must ignore
	localparam logic [2:0] OpUnusedLo = 3'd5;
	localparam logic [2:0] OpUnusedHi = 3'd7;
	// effect code outside the known set, stored as none
	localparam logic [1:0] FxUnknown  = 2'd3;

	typedef struct packed {
		logic [2:0] op;
		logic       switch_on;
		color_t     color;
		logic [7:0] brightness;
		logic [1:0] effect;
	} lamp_event_t;

	typedef struct packed {
		logic       on;
		color_t     color;
		logic [7:0] brightness;
		logic [1:0] effect;
	} lamp_view_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [ItemWidth-1:0] s_tdata  = '0;
	logic [OpWidth-1:0]   s_tuser  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [ItemWidth-1:0] m_tdata;

	always #6 clk = ~clk;

	rgb_lamp_effect_controller_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// lamp model state, starts at the reset values
	color_t     lamp_shown  = ColorBlack;
	color_t     lamp_saved  = ColorWhite;
	logic [7:0] lamp_level  = LevelMax;
	logic [1:0] lamp_effect = FX_NONE;
	color_t     wheel_pos   = ColorBlack;
	logic [7:0] pulse_level = 8'd0;
	logic       pulse_up    = 1'b1;

	lamp_event_t queued_events[$];
	lamp_view_t  awaited_views[$];
	lamp_event_t offered_event;
	logic        offer_taken    = 1'b0;
	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	int          rx_hold_req    = 0;
	int          rx_hold_left   = 0;
	int          mismatch_count = 0;
	int          cycle_count    = 0;

	// one unit along the six sides of the color wheel; off the wheel nothing moves
	function automatic color_t wheel_step(color_t c);
		color_t n;
		n = c;
		if (c.red == LevelMax && c.green != LevelMax && c.blue == 8'h00)
			n.green = c.green + 8'd1;
		else if (c.red != 8'h00 && c.green == LevelMax && c.blue == 8'h00)
			n.red = c.red - 8'd1;
		else if (c.red == 8'h00 && c.green == LevelMax && c.blue != LevelMax)
			n.blue = c.blue + 8'd1;
		else if (c.red == 8'h00 && c.green != 8'h00 && c.blue == LevelMax)
			n.green = c.green - 8'd1;
		else if (c.red != LevelMax && c.green == 8'h00 && c.blue == LevelMax)
			n.red = c.red + 8'd1;
		else if (c.red == LevelMax && c.green == 8'h00 && c.blue != 8'h00)
			n.blue = c.blue - 8'd1;
		return n;
	endfunction

	// apply one accepted event to the lamp model and queue the view it yields
	task automatic apply_lamp_event(input lamp_event_t ev);
		int         lvl;
		logic [1:0] sel;
		lamp_view_t view;
		case (ev.op)
			OP_TICK: begin
				if (lamp_effect == FX_RAINBOW) begin
					lamp_shown = wheel_pos;
					wheel_pos  = wheel_step(wheel_pos);
				end else if (lamp_effect == FX_PULSE) begin
					lvl = int'(pulse_level);
					if (lvl == 0)
						pulse_up = 1'b1;
					else if (lvl == int'(LevelMax))
						pulse_up = 1'b0;
					lvl = pulse_up ? lvl + int'(PulseStep) : lvl - int'(PulseStep);
					if (lvl < 0)
						lvl = 0;
					if (lvl > int'(LevelMax))
						lvl = int'(LevelMax);
					pulse_level = lvl[7:0];
					lamp_level  = pulse_level;
				end
			end
			OP_TOGGLE: begin
				if (ev.switch_on) begin
					lamp_shown = lamp_saved;
				end else begin
					lamp_saved = lamp_shown;
					lamp_shown = ColorBlack;
				end
			end
			OP_SET_COLOR: begin
				lamp_saved = ev.color;
				lamp_shown = ev.color;
			end
			OP_SET_BRIGHT: lamp_level = ev.brightness;
			OP_SET_EFFECT: begin
				sel = (ev.effect > FX_PULSE) ? FX_NONE : ev.effect;
				lamp_effect = sel;
				if (sel == FX_RAINBOW) begin
					wheel_pos = lamp_shown;
				end else if (sel == FX_PULSE) begin
					pulse_level = lamp_level;
					pulse_up    = 1'b0;
				end
			end
			default: ;
		endcase
		view.on         = |lamp_shown;
		view.color      = lamp_shown;
		view.brightness = lamp_level;
		view.effect     = lamp_effect;
		awaited_views.push_back(view);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
	endtask

	task automatic check_lamp_view(input logic [ItemWidth-1:0] word);
		lamp_view_t want;
		if (awaited_views.size() == 0) begin
			report_mismatch("unexpected result", int'(word[31:0]), 0);
		end else begin
			want = awaited_views.pop_front();
			if (word[0] !== want.on)
				report_mismatch("lamp_on", int'(word[0]), int'(want.on));
			if (word[8:1] !== want.color.red)
				report_mismatch("red", int'(word[8:1]), int'(want.color.red));
			if (word[16:9] !== want.color.green)
				report_mismatch("green", int'(word[16:9]), int'(want.color.green));
			if (word[24:17] !== want.color.blue)
				report_mismatch("blue", int'(word[24:17]), int'(want.color.blue));
			if (word[32:25] !== want.brightness)
				report_mismatch("brightness", int'(word[32:25]), int'(want.brightness));
			if (word[34:33] !== want.effect)
				report_mismatch("effect", int'(word[34:33]), int'(want.effect));
		end
	endtask

	task automatic push_event(input logic [2:0] op, input logic sw, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b, input logic [7:0] bri,
			input logic [1:0] fx);
		lamp_event_t ev;
		ev.op         = op;
		ev.switch_on  = sw;
		ev.color      = '{blue: b, green: g, red: r};
		ev.brightness = bri;
		ev.effect     = fx;
		queued_events.push_back(ev);
	endtask

	// mostly meaningful events, colors often placed on a wheel edge so rainbow walks far
	function automatic lamp_event_t random_lamp_event();
		lamp_event_t ev;
		int unsigned pick;
		logic [7:0]  v;
		ev.switch_on   = 1'($urandom_range(1));
		ev.color.red   = 8'($urandom);
		ev.color.green = 8'($urandom);
		ev.color.blue  = 8'($urandom);
		ev.brightness  = 8'($urandom);
		ev.effect      = 2'($urandom_range(3));
		pick = $urandom_range(99);
		if (pick < 45) begin
			ev.op = OP_TICK;
		end else if (pick < 58) begin
			ev.op = OP_TOGGLE;
		end else if (pick < 71) begin
			ev.op = OP_SET_COLOR;
			v = 8'($urandom);
			case ($urandom_range(8))
				0: ev.color = '{blue: 8'h00, green: v, red: LevelMax};
				1: ev.color = '{blue: 8'h00, green: LevelMax, red: v};
				2: ev.color = '{blue: v, green: LevelMax, red: 8'h00};
				3: ev.color = '{blue: LevelMax, green: v, red: 8'h00};
				4: ev.color = '{blue: LevelMax, green: 8'h00, red: v};
				5: ev.color = '{blue: v, green: 8'h00, red: LevelMax};
				6: ev.color = ColorBlack;
				default: ;
			endcase
		end else if (pick < 81) begin
			ev.op = OP_SET_BRIGHT;
			case ($urandom_range(4))
				0: ev.brightness = 8'd0;
				1: ev.brightness = LevelMax;
				default: ;
			endcase
		end else if (pick < 96) begin
			ev.op = OP_SET_EFFECT;
		end else begin
			ev.op = 3'($urandom_range(int'(OpUnusedHi), int'(OpUnusedLo)));
		end
		return ev;
	endfunction

	// wait until the core has nothing left in flight
	task automatic wait_idle();
		while (queued_events.size() != 0 || awaited_views.size() != 0 || s_tvalid)
			@(posedge clk);
	endtask

	// checker: results first, then the event accepted at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				check_lamp_view(m_tdata);
			if (s_tvalid && s_tready) begin
				apply_lamp_event(offered_event);
				offer_taken = 1'b1;
			end
		end
	end

	// event driver, changes the slave side at the falling edge
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || offer_taken)) begin
			offer_taken = 1'b0;
			if (queued_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				offered_event = queued_events.pop_front();
				s_tvalid <= 1'b1;
				// zero fill, effect, brightness, blue, green, red, switch_on
				s_tdata  <= {5'b0, offered_event.effect, offered_event.brightness,
					offered_event.color, offered_event.switch_on};
				s_tuser  <= offered_event.op;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result sink, random stalls plus an occasional long hold-off
	always @(negedge clk) begin
		if (rx_hold_req != 0) begin
			rx_hold_left = rx_hold_req;
			rx_hold_req  = 0;
		end
		if (rx_hold_left != 0) begin
			rx_hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin : watchdog
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : stimulus
		lamp_event_t ev;
		int          added;
		int          burst;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// reset view through an ignored operation, all argument bits high
		push_event(OpUnusedLo, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, FxUnknown);
		// toggle off twice: the second save stores black, so toggle on stays black
		push_event(OP_TOGGLE, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, FX_NONE);
		push_event(OP_TOGGLE, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, FxUnknown);
		push_event(OP_TOGGLE, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, FX_NONE);
		push_event(OP_SET_COLOR, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, FX_PULSE);
		push_event(OP_TOGGLE, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, FX_NONE);
		push_event(OP_TOGGLE, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, FX_NONE);
		// pulse from level 0: turns upward
		push_event(OP_SET_BRIGHT, 1'b0, 8'h00, 8'h00, 8'h00, 8'd0, FX_NONE);
		push_event(OP_SET_EFFECT, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, FX_PULSE);
		push_event(OP_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, FX_NONE);
		push_event(OP_TICK, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, FxUnknown);
		// pulse from level 1 falling: clamps at zero
		push_event(OP_SET_BRIGHT, 1'b0, 8'h00, 8'h00, 8'h00, 8'd1, FX_NONE);
		push_event(OP_SET_EFFECT, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, FX_PULSE);
		push_event(OP_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, FX_NONE);
		// pulse from the top level
		push_event(OP_SET_BRIGHT, 1'b0, 8'h00, 8'h00, 8'h00, LevelMax, FX_NONE);
		push_event(OP_SET_EFFECT, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, FX_PULSE);
		push_event(OP_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, FX_NONE);
		// rainbow across the yellow corner of the wheel
		push_event(OP_SET_COLOR, 1'b1, 8'hFF, 8'hFE, 8'h00, 8'h00, FX_NONE);
		push_event(OP_SET_EFFECT, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, FX_RAINBOW);
		push_event(OP_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, FX_NONE);
		push_event(OP_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, FX_NONE);
		// rainbow from black sits off the wheel and never moves
		push_event(OP_SET_COLOR, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, FX_NONE);
		push_event(OP_SET_EFFECT, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, FX_RAINBOW);
		push_event(OP_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, FX_NONE);
		// unknown effect code falls back to none
		push_event(OP_SET_EFFECT, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, FxUnknown);
		push_event(OpUnusedHi, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, FX_NONE);
		wait_idle();

		// idling phases: none, sender gaps, receiver stalls, both
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
					// long sink hold-off while events keep coming, fills the pipe
					rx_hold_req    = LongHold;
				end
				1: begin
					send_idle_pct  = 56;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 56;
				end
				default: begin
					send_idle_pct  = 32;
					recv_stall_pct = 32;
				end
			endcase
			added = 0;
			while (added < RandomPerPhase) begin
				ev = random_lamp_event();
				queued_events.push_back(ev);
				added++;
				// ticks come in runs so effects get to travel
				if (ev.op == OP_TICK) begin
					burst = $urandom_range(12);
					repeat (burst) begin
						ev    = random_lamp_event();
						ev.op = OP_TICK;
						queued_events.push_back(ev);
						added++;
					end
				end
			end
			// sender stays quiet until every awaited view is back
			wait_idle();
		end

		repeat (DrainCycles) @(posedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
